>>> src/lzfd_pkg.sv
// lzfd_pkg: shared constants and types for the flag-bit lz decompressor
// no dependencies
`default_nettype none
package lzfd_pkg;
    localparam int HistDepth = 8192;
    localparam int PosW = 13;
    localparam int LenW = 16;
    localparam int MaxBurst = 64;
    localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_IDLE_DRAIN = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       copy_pending;
        logic       stream_end;
        logic [1:0] status;
    } out_word_t;
endpackage
`default_nettype wire

>>> src/lzfd_if.sv
// lzfd_if: valid/ready channel carrying one word
// depends on lzfd_pkg
`default_nettype none
interface lzfd_in_if;
    logic valid;
    logic ready;
    lzfd_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lzfd_out_if;
    logic valid;
    logic ready;
    lzfd_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/lzfd_hist_ram.sv
// lzfd_hist_ram: history memory with one write and one registered read port
// depends on lzfd_pkg
`default_nettype none
module lzfd_hist_ram (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [lzfd_pkg::PosW-1:0] waddr,
    input  wire logic [7:0]                wdata,
    input  wire logic [lzfd_pkg::PosW-1:0] raddr,
    output logic [7:0]                     rdata
);
    logic [7:0] mem [lzfd_pkg::HistDepth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> src/lz_flag_bit_decompressor_unit.sv
// lz_flag_bit_decompressor_unit: top level of the flag-bit lz decompressor
// depends on lzfd_pkg, lzfd_if, lzfd_hist_ram
//
// Takes one compressed byte (or a drain request) per input word and emits the
// decompressed words it causes, the final one marked by last. A sequencer
// walks the flag bits one per cycle, waiting in idle whenever it needs a new
// byte, and refills the flag byte when all its bits are used. A match copy
// reads the history ram one byte at a time. Each copied byte goes through a
// wait for the output register while the ram read is issued, then write back
// and hand over, then a check for the end of the copy or burst. A burst is at
// most 64 bytes. After reset the history is cleared by a sweep over all 8192
// entries, during which no input word is taken. The input is not ready while a word is at work.
`default_nettype none
module lz_flag_bit_decompressor_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lzfd_in_if.sink    in_ch,
    lzfd_out_if.source out_ch
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PARSE, S_LIT, S_END, S_CRD, S_CWAIT, S_COUT, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_MAIN, PH_LIT, PH_OFFSET, PH_NIB, PH_GCONT, PH_GDATA, PH_END
    } phase_t;

    localparam int PW = lzfd_pkg::PosW;
    localparam int LW = lzfd_pkg::LenW;

    state_t            state_reg;
    phase_t            phase_reg;
    logic [PW-1:0]     wpos_reg, rpos_reg, off_reg;
    logic [7:0]        flags_reg, byte_reg;
    logic [3:0]        left_reg;
    logic [2:0]        nib_reg;
    logic [LW-1:0]     gamma_reg, remain_reg;
    logic              ended_reg, have_reg;
    logic [6:0]        burst_reg;
    logic [1:0]        cstat_reg;
    lzfd_pkg::out_word_t obuf_reg;
    logic              ovalid_reg;

    // ram port
    logic          we;
    logic [PW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    lzfd_hist_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // current flag bit
    logic bit_cur;
    assign bit_cur = flags_reg[left_reg[2:0] - 3'd1];

    always_comb
    begin
        we    = 1'b0;
        waddr = wpos_reg;
        wdata = byte_reg;
        raddr = rpos_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                wdata = 8'd0;
            end
            S_LIT:   we = 1'b1;
            S_CWAIT:
            begin
                we    = 1'b1;
                wdata = rdata;
            end
            default: we = 1'b0;
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = obuf_reg;

    logic [LW:0] gnext;
    assign gnext = {gamma_reg, bit_cur};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            phase_reg  <= PH_MAIN;
            wpos_reg   <= '0;
            rpos_reg   <= '0;
            off_reg    <= '0;
            flags_reg  <= '0;
            left_reg   <= '0;
            nib_reg    <= '0;
            gamma_reg  <= LW'(1);
            remain_reg <= '0;
            ended_reg  <= 1'b0;
            have_reg   <= 1'b0;
            burst_reg  <= '0;
            cstat_reg  <= lzfd_pkg::ST_OK;
            ovalid_reg <= 1'b0;
            byte_reg   <= '0;
            obuf_reg   <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    wpos_reg <= wpos_reg + PW'(1);
                    if (wpos_reg == PW'(lzfd_pkg::HistDepth - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        byte_reg  <= in_ch.data.in_byte;
                        burst_reg <= '0;
                        if (remain_reg != '0)
                        begin
                            cstat_reg <= lzfd_pkg::ST_OK;
                            state_reg <= S_CRD;
                        end
                        else if (in_ch.data.mode)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (!ended_reg)
                        begin
                            have_reg  <= 1'b1;
                            state_reg <= S_PARSE;
                        end
                    end
                end
                S_PARSE:
                begin
                    if (phase_reg == PH_LIT)
                    begin
                        if (have_reg)
                        begin
                            have_reg  <= 1'b0;
                            phase_reg <= PH_MAIN;
                            state_reg <= S_LIT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (left_reg == '0)
                    begin
                        if (have_reg)
                        begin
                            have_reg  <= 1'b0;
                            flags_reg <= byte_reg;
                            left_reg  <= 4'd8;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_MAIN:
                            begin
                                left_reg  <= left_reg - 4'd1;
                                phase_reg <= bit_cur ? PH_OFFSET : PH_LIT;
                            end
                            PH_OFFSET:
                            begin
                                if (!have_reg)
                                begin
                                    state_reg <= S_IDLE;
                                end
                                else
                                begin
                                    have_reg <= 1'b0;
                                    left_reg <= left_reg - 4'd1;
                                    if (!bit_cur)
                                    begin
                                        if (byte_reg == 8'd0)
                                        begin
                                            ended_reg <= 1'b1;
                                            phase_reg <= PH_END;
                                            state_reg <= S_END;
                                        end
                                        else
                                        begin
                                            off_reg   <= PW'(9'd256 - {1'b0, byte_reg});
                                            gamma_reg <= LW'(1);
                                            phase_reg <= PH_GCONT;
                                        end
                                    end
                                    else
                                    begin
                                        off_reg   <= PW'(byte_reg);
                                        nib_reg   <= '0;
                                        phase_reg <= PH_NIB;
                                    end
                                end
                            end
                            PH_NIB:
                            begin
                                left_reg <= left_reg - 4'd1;
                                if (nib_reg == 3'd3)
                                begin
                                    nib_reg   <= '0;
                                    off_reg   <= PW'(13'd4351 - {1'b0, off_reg[10:0], bit_cur});
                                    gamma_reg <= LW'(1);
                                    phase_reg <= PH_GCONT;
                                end
                                else
                                begin
                                    nib_reg <= nib_reg + 3'd1;
                                    off_reg <= {off_reg[PW-2:0], bit_cur};
                                end
                            end
                            PH_GCONT:
                            begin
                                left_reg <= left_reg - 4'd1;
                                if (bit_cur)
                                begin
                                    phase_reg <= PH_GDATA;
                                end
                                else
                                begin
                                    phase_reg <= PH_MAIN;
                                    if (gamma_reg == lzfd_pkg::LenMax)
                                    begin
                                        remain_reg <= lzfd_pkg::LenMax;
                                        cstat_reg  <= lzfd_pkg::ST_SAT;
                                    end
                                    else
                                    begin
                                        remain_reg <= gamma_reg + LW'(1);
                                        cstat_reg  <= lzfd_pkg::ST_OK;
                                    end
                                    rpos_reg  <= wpos_reg - off_reg;
                                    state_reg <= S_CRD;
                                end
                            end
                            PH_GDATA:
                            begin
                                left_reg  <= left_reg - 4'd1;
                                gamma_reg <= gnext[LW] ? lzfd_pkg::LenMax : gnext[LW-1:0];
                                phase_reg <= PH_GCONT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_LIT:
                begin
                    // literal written to history this cycle
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        wpos_reg   <= wpos_reg + PW'(1);
                        obuf_reg   <= '{byte_reg, 1'b1, 1'b1, 1'b0, ended_reg,
                                        lzfd_pkg::ST_OK};
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_END:
                begin
                    // end marker word, loaded once the output register is free
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        obuf_reg   <= '{8'd0, 1'b0, 1'b1, 1'b0, 1'b1, lzfd_pkg::ST_OK};
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_CRD:
                begin
                    // wait for the output register to free before each read
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        state_reg <= S_CWAIT;
                    end
                end
                S_CWAIT:
                begin
                    // rdata valid; written back to history this cycle
                    obuf_reg <= '{rdata, 1'b1,
                                  (remain_reg == LW'(1)) || (burst_reg == 7'(lzfd_pkg::MaxBurst - 1)),
                                  remain_reg != LW'(1), ended_reg, cstat_reg};
                    ovalid_reg <= 1'b1;
                    wpos_reg   <= wpos_reg + PW'(1);
                    rpos_reg   <= rpos_reg + PW'(1);
                    remain_reg <= remain_reg - LW'(1);
                    burst_reg  <= burst_reg + 7'd1;
                    state_reg  <= S_COUT;
                end
                S_COUT:
                begin
                    if ((remain_reg == '0) || (burst_reg == 7'(lzfd_pkg::MaxBurst)))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_CRD;
                    end
                end
                S_OUT:
                begin
                    // drain with nothing pending, loaded once the output register is free
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        obuf_reg   <= '{8'd0, 1'b0, 1'b1, 1'b0, ended_reg,
                                        lzfd_pkg::ST_IDLE_DRAIN};
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a copy word is never loaded over an untaken one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CWAIT) |-> (!ovalid_reg || out_ch.ready))
        else $error("copy word overwrote pending output");

    // the burst never exceeds its limit
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        burst_reg <= 7'(lzfd_pkg::MaxBurst))
        else $error("burst count over limit");

    // no input taken during the clearing sweep
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ch.ready)
        else $error("input ready while clearing");

    // once ended, the end flag stays
    a_ended: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ended_reg) |-> ended_reg)
        else $error("end flag dropped");
endmodule
`default_nettype wire

>>> sim/lzfd_checker.sv
// lzfd_checker: watches both channels of the decompressor, predicts every output word
// depends on lzfd_pkg and lzfd_if
`timescale 1ns / 100ps
module lzfd_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    lzfd_in_if        in_mon,
    lzfd_out_if       out_mon,
    output int        fail_count,
    output int        words_waiting,
    output int        words_seen
);
    typedef enum int {
        P_MAIN, P_LIT, P_OFFSET, P_NIB, P_GCONT, P_GDATA, P_END
    } parse_t;

    localparam int PW = lzfd_pkg::PosW;

    logic [7:0]      hist_mem [lzfd_pkg::HistDepth];
    logic [PW-1:0]   wr_pos;
    logic [PW-1:0]   rd_pos;
    logic [PW-1:0]   distance;
    logic [7:0]      flag_reg;
    int              flags_left;
    parse_t          phase;
    int              nib_cnt;
    int              gamma;
    int              copy_left;
    bit              stream_done;

    lzfd_pkg::out_word_t word_burst [$];
    lzfd_pkg::out_word_t expected_words [$];

    function automatic bit next_flag();
        flags_left--;
        return flag_reg[flags_left];
    endfunction

    function automatic void note_word(logic [7:0] b, logic v, logic [1:0] st);
        lzfd_pkg::out_word_t w;
        w.out_byte     = b;
        w.byte_valid   = v;
        w.last         = 1'b0;
        w.copy_pending = copy_left > 0;
        w.stream_end   = stream_done;
        w.status       = st;
        word_burst.push_back(w);
    endfunction

    function automatic void store_byte(logic [7:0] b);
        hist_mem[wr_pos] = b;
        wr_pos++;
    endfunction

    function automatic void run_copy(logic [1:0] st);
        logic [7:0] b;
        int k;
        k = 0;
        while (copy_left > 0 && k < lzfd_pkg::MaxBurst)
        begin
            b = hist_mem[rd_pos];
            rd_pos++;
            store_byte(b);
            copy_left--;
            note_word(b, 1'b1, st);
            k++;
        end
    endfunction

    function automatic void begin_copy();
        logic [1:0] st;
        st = lzfd_pkg::ST_OK;
        copy_left = gamma + 1;
        if (gamma >= int'(lzfd_pkg::LenMax))
        begin
            copy_left = int'(lzfd_pkg::LenMax);
            st = lzfd_pkg::ST_SAT;
        end
        rd_pos = wr_pos - distance;  // ring of a power of two wraps by itself
        phase = P_MAIN;
        run_copy(st);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        bit have;
        int v;
        have = 1'b1;
        forever
        begin
            if (copy_left > 0 || phase == P_END)
                return;
            if (phase == P_LIT)
            begin
                if (!have)
                    return;
                have = 1'b0;
                store_byte(b);
                note_word(b, 1'b1, lzfd_pkg::ST_OK);
                phase = P_MAIN;
                continue;
            end
            if (flags_left == 0)
            begin
                if (!have)
                    return;
                have = 1'b0;
                flag_reg = b;
                flags_left = 8;
                continue;
            end
            case (phase)
                P_MAIN: phase = next_flag() ? P_OFFSET : P_LIT;
                P_OFFSET:
                begin
                    if (!have)
                        return;
                    have = 1'b0;
                    if (!next_flag())
                    begin
                        if (b == 8'd0)
                        begin
                            stream_done = 1'b1;
                            phase = P_END;
                            note_word(8'd0, 1'b0, lzfd_pkg::ST_OK);
                            return;
                        end
                        distance = 13'd256 - {5'd0, b};
                        gamma = 1;
                        phase = P_GCONT;
                    end
                    else
                    begin
                        distance = {5'd0, b};
                        nib_cnt = 0;
                        phase = P_NIB;
                    end
                end
                P_NIB:
                begin
                    distance = {distance[PW-2:0], next_flag()};
                    nib_cnt++;
                    if (nib_cnt >= 4)
                    begin
                        nib_cnt = 0;
                        distance = 13'd4351 - {1'b0, distance[11:0]};
                        gamma = 1;
                        phase = P_GCONT;
                    end
                end
                P_GCONT:
                begin
                    if (next_flag())
                        phase = P_GDATA;
                    else
                        begin_copy();
                end
                P_GDATA:
                begin
                    v = gamma * 2 + int'(next_flag());
                    gamma = (v > int'(lzfd_pkg::LenMax)) ? int'(lzfd_pkg::LenMax) : v;
                    phase = P_GCONT;
                end
                default: phase = P_MAIN;
            endcase
        end
    endfunction

    function automatic void predict_word(lzfd_pkg::in_word_t w);
        word_burst.delete();
        if (copy_left > 0)
            run_copy(lzfd_pkg::ST_OK);
        else if (w.mode)
            note_word(8'd0, 1'b0, lzfd_pkg::ST_IDLE_DRAIN);
        else if (!stream_done)
            decode_byte(w.in_byte);
        if (word_burst.size() > 0)
            word_burst[$].last = 1'b1;
        foreach (word_burst[i])
            expected_words.push_back(word_burst[i]);
    endfunction

    function automatic void field_check(string name, int want, int got);
        if (want != got)
        begin
            $error("field %s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin
        foreach (hist_mem[i])
            hist_mem[i] = 8'd0;
        wr_pos = '0;
        rd_pos = '0;
        distance = '0;
        flag_reg = '0;
        flags_left = 0;
        phase = P_MAIN;
        nib_cnt = 0;
        gamma = 1;
        copy_left = 0;
        stream_done = 1'b0;
        fail_count = 0;
        words_seen = 0;
        words_waiting = 0;
    end

    always @(posedge clk)
    begin
        lzfd_pkg::out_word_t want;
        lzfd_pkg::out_word_t got;
        if (rst_n)
        begin
            if (in_mon.valid && in_mon.ready)
                predict_word(in_mon.data);
            if (out_mon.valid && out_mon.ready)
            begin
                got = out_mon.data;
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    $error("output word with nothing expected: %h", got);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    field_check("out_byte", want.out_byte, got.out_byte);
                    field_check("byte_valid", want.byte_valid, got.byte_valid);
                    field_check("last", want.last, got.last);
                    field_check("copy_pending", want.copy_pending, got.copy_pending);
                    field_check("stream_end", want.stream_end, got.stream_end);
                    field_check("status", want.status, got.status);
                end
            end
            words_waiting = expected_words.size();
        end
    end
endmodule

>>> sim/lz_flag_bit_decompressor_unit_tb.sv
// lz_flag_bit_decompressor_unit_tb: builds one well-formed compressed stream and feeds it
// depends on lzfd_pkg, lzfd_if, lz_flag_bit_decompressor_unit and lzfd_checker
`timescale 1ns / 100ps
module lz_flag_bit_decompressor_unit_tb;
    logic clk;
    logic rst_n;

    lzfd_in_if  in_bus ();
    lzfd_out_if out_bus ();

    int fail_count;
    int words_waiting;
    int words_seen;

    // stream under construction: one compressed byte per entry, plus how many
    // drain words must follow it while its copy is still running
    logic [7:0] stream_bytes [$];
    int         drains_after [$];
    int         flag_slot;
    int         flag_free;

    int  words_sent;
    int  matches_built;
    int  literals_built;
    bit  steady;
    bit  hold_done;
    int  hold_left;
    bit  timed_out;

    lz_flag_bit_decompressor_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    lzfd_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_bus),
        .out_mon       (out_bus),
        .fail_count    (fail_count),
        .words_waiting (words_waiting),
        .words_seen    (words_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // hard stop, well beyond the history clear sweep plus the whole stream
    initial
    begin
        #2000000;
        $display("timeout with %0d words still expected", words_waiting);
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------------------
    // stream encoder
    // ---------------------------------------------------------------------------

    function automatic void put_byte(logic [7:0] b);
        stream_bytes.push_back(b);
        drains_after.push_back(0);
    endfunction

    // a fresh flag byte is placed in the stream as soon as a bit is needed
    function automatic void make_room();
        if (flag_free == 0)
        begin
            put_byte(8'd0);
            flag_slot = stream_bytes.size() - 1;
            flag_free = 8;
        end
    endfunction

    function automatic void put_bit(bit b);
        make_room();
        flag_free--;
        stream_bytes[flag_slot][flag_free] = b;
    endfunction

    function automatic void put_literal(logic [7:0] b);
        put_bit(1'b0);
        put_byte(b);
        literals_built++;
    endfunction

    // count is the gamma value; the copy is count + 1 bytes, clamped
    function automatic void put_match(bit far, logic [7:0] off, logic [3:0] nib, int count);
        int msb;
        int span;
        put_bit(1'b1);
        make_room();          // type bit refill comes before the offset byte
        put_byte(off);
        put_bit(far);
        if (far)
            for (int i = 3; i >= 0; i--)
                put_bit(nib[i]);
        msb = 0;
        for (int i = 0; i < 17; i++)
            if (count[i])
                msb = i;
        for (int i = msb - 1; i >= 0; i--)
        begin
            put_bit(1'b1);
            put_bit(count[i]);
        end
        put_bit(1'b0);
        // the copy starts on the item of the last byte placed so far
        span = (count + 1 > int'(lzfd_pkg::LenMax)) ? int'(lzfd_pkg::LenMax) : count + 1;
        if (span > lzfd_pkg::MaxBurst)
            drains_after[$] += (span - 1) / lzfd_pkg::MaxBurst;
        matches_built++;
    endfunction

    function automatic void put_end_marker();
        put_bit(1'b1);
        make_room();
        put_byte(8'd0);
        put_bit(1'b0);
    endfunction

    // ---------------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------------

    task automatic push_word(logic mode, logic [7:0] b);
        lzfd_pkg::in_word_t w;
        w.mode = mode;
        w.in_byte = b;
        while (!steady && $urandom_range(99) < 15)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= w;
        @(posedge clk iff (in_bus.valid && in_bus.ready));
        words_sent++;
        steady = (words_sent >= 120 && words_sent < 180);
    endtask

    // sends the stream; a copy in flight gets its drain words, some of which
    // are replaced by a stray byte that the block must treat as a drain
    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++)
        begin
            push_word(1'b0, stream_bytes[i]);
            for (int d = 0; d < drains_after[i]; d++)
            begin
                if ($urandom_range(99) < 20)
                    push_word(1'b0, 8'($urandom));
                else
                    push_word(1'b1, 8'($urandom));
            end
            // idle drain with nothing pending
            if (drains_after[i] == 0 && $urandom_range(99) < 5)
                push_word(1'b1, 8'($urandom));
        end
    endtask

    // ---------------------------------------------------------------------------
    // output side: random stalls, a calm stretch and one long hold-off
    // ---------------------------------------------------------------------------

    initial
    begin
        out_bus.ready = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && words_sent >= 40)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else if (steady)
                out_bus.ready <= 1'b1;
            else
                out_bus.ready <= ($urandom_range(99) >= 15);
        end
    end

    // ---------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------

    initial
    begin
        int tail;
        in_bus.valid = 1'b0;
        in_bus.data  = '0;
        rst_n = 1'b0;
        words_sent = 0;
        matches_built = 0;
        literals_built = 0;
        steady = 1'b0;
        timed_out = 1'b0;
        flag_slot = 0;
        flag_free = 0;

        // directed part: byte extremes, both offset kinds at their extremes,
        // reads from the cleared history, copies across the burst limit
        put_literal(8'h00);
        put_literal(8'hFF);
        put_match(1'b0, 8'h01, 4'h0, 3);      // distance 255, reads cleared history
        put_match(1'b1, 8'h00, 4'h0, 2);      // longest distance, cleared history
        put_literal(8'hA5);
        put_literal(8'h5A);
        put_match(1'b0, 8'hFF, 4'h0, 1);      // distance one, shortest copy
        put_match(1'b1, 8'hFF, 4'hF, 63);     // exactly one full burst
        put_match(1'b0, 8'hFE, 4'h0, 70);     // spills into one drain
        put_match(1'b1, 8'h9C, 4'h6, 130);

        // random part
        while (stream_bytes.size() < 170)
        begin
            if ($urandom_range(1))
                put_literal(8'($urandom));
            else
                put_match(1'($urandom), 8'($urandom_range(255, 1)), 4'($urandom),
                          ($urandom_range(99) < 80) ? $urandom_range(20, 1)
                                                   : $urandom_range(300, 21));
        end
        put_end_marker();
        tail = stream_bytes.size();
        for (int i = 0; i < 3; i++)
            put_byte(8'($urandom));           // ignored after the end marker
        drains_after[tail - 1] = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_stream();
        push_word(1'b1, 8'($urandom));        // drain after the end
        in_bus.valid <= 1'b0;

        for (int c = 0; c < 200000 && words_waiting > 0; c++)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("stream of %0d bytes: %0d literals, %0d matches, %0d input words",
                 stream_bytes.size(), literals_built, matches_built, words_sent);
        $display("%0d output words checked, %0d still expected", words_seen, words_waiting);
        if (fail_count == 0 && words_waiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
